// ===== rtl/lsc_pkg.sv =====
package lsc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 22;
  // +-4.0 with FRAC_BITS fraction bits, sign included
  localparam int HELD_W      = FRAC_BITS + 4;
  localparam int IN_GAIN_W   = 22;
  localparam int OUT_GAIN_W  = 17;
  localparam int GAIN_FRAC   = 16;
  localparam int WEIGHT_W    = 30;
  localparam int MUL_B_W     = WEIGHT_W;
  localparam int PROD_W      = HELD_W + MUL_B_W + 1;

  localparam int IN_SHIFT    = SAMPLE_BITS - 1 + GAIN_FRAC - FRAC_BITS;
  localparam int OUT_SHIFT   = FRAC_BITS + GAIN_FRAC - (SAMPLE_BITS - 1);
  localparam int BLEND_SHIFT = WEIGHT_W;

  localparam longint W_HARD   = 64'sd793586619;
  localparam longint W_SOFT   = (longint'(1) <<< WEIGHT_W) - W_HARD;
  localparam longint CLIP_Q30 = 64'sd1025415481;
  localparam longint CLIP_LVL = CLIP_Q30 >>> (WEIGHT_W - FRAC_BITS);
  localparam longint FOUR     = longint'(4) <<< FRAC_BITS;
  localparam longint K_RH     = CLIP_LVL * W_HARD;
  localparam longint K_RS     = CLIP_LVL * W_SOFT;
  localparam longint SMAX     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN     = -SMAX - 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = IN_GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IN_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = CFG_IDX_W'(2);

  localparam logic [IN_GAIN_W-1:0]  IN_GAIN_RST  = IN_GAIN_W'(1 << GAIN_FRAC);
  localparam logic [OUT_GAIN_W-1:0] OUT_GAIN_RST = OUT_GAIN_W'(1 << GAIN_FRAC);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [HELD_W-1:0]      held_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef enum logic [2:0] {
    OP_IN,
    OP_POS_X,
    OP_POS_H,
    OP_CLIP_P,
    OP_NEG_X,
    OP_NEG_H,
    OP_CLIP_N,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic wb;
    logic publish;
    op_t  op;
    logic ch;
  } dp_cmd_t;

  typedef struct packed {
    logic       bypass;
    logic [1:0] pos_flag;
    logic [1:0] neg_flag;
    logic       x_gt_clip;
    logic       x_lt_nclip;
    logic       x_lt_held;
    logic       x_gt_held;
  } dp_stat_t;

endpackage

// ===== rtl/lsc_in_if.sv =====
interface lsc_in_if;
  import lsc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/lsc_out_if.sv =====
interface lsc_out_if;
  import lsc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/lsc_cfg_if.sv =====
interface lsc_cfg_if;
  import lsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lookahead_soft_clipper_stereo.sv =====
// Each input pair takes N = 4..8 multiply ops (gain in, up to two blends, gain out, per
// channel); in bypass it skips them. One pair is in flight at a time: a new pair is
// accepted only once the last one is published. A single shared multiplier serves
// every op, each with a multiply step and a write-back step. A result held off
// at the output stalls the next computed pair until the output register frees up.
// Reset (rst_n low, synchronous): held samples and clip flags cleared, bypass off,
// both gains 1.0, no result pending.
module lookahead_soft_clipper_stereo (
  input logic       clk,
  input logic       rst_n,
  lsc_in_if.sink    in_chan,
  lsc_out_if.source out_chan,
  lsc_cfg_if.sink   cfg_chan
);
  import lsc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  lsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_chan.valid && cfg_chan.ready),
    .cfg_idx   (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .in_left   (in_chan.left_sample),
    .in_right  (in_chan.right_sample),
    .out_left  (out_chan.left_out),
    .out_right (out_chan.right_out),
    .stat      (stat)
  );

  // between transactions a channel never carries both clip flags
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (stat.pos_flag & stat.neg_flag) == 2'b00)
    else $error("positive and negative clip flags both set");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul || cmd.wb) |-> !in_chan.ready)
    else $error("input ready while datapath busy");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !stat.bypass) |=> cmd.mul)
    else $error("accepted transaction did not start processing");

  a_publish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_chan.valid)
    else $error("published result not presented");

endmodule

// ===== rtl/lsc_dp.sv =====
module lsc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsc_pkg::dp_cmd_t              cmd,
  input  logic                          cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lsc_pkg::sample_t              in_left,
  input  lsc_pkg::sample_t              in_right,
  output lsc_pkg::sample_t              out_left,
  output lsc_pkg::sample_t              out_right,
  output lsc_pkg::dp_stat_t             stat
);
  import lsc_pkg::*;

  logic                  bypass_r;
  logic [IN_GAIN_W-1:0]  in_gain_r;
  logic [OUT_GAIN_W-1:0] out_gain_r;

  sample_t    smp_r [2];
  held_t      held_r [2];
  logic [1:0] pos_r;
  logic [1:0] neg_r;
  held_t      x_r;
  prod_t      p_r;
  sample_t    y_r [2];
  sample_t    out_left_r;
  sample_t    out_right_r;

  held_t              mul_a;
  logic [MUL_B_W-1:0] mul_b;
  prod_t              prod;
  prod_t              k;
  prod_t              sum;
  prod_t              sh_in;
  prod_t              sh_out;
  prod_t              sh_bl;
  held_t              x_in;
  held_t              blend;
  sample_t            y_sat;

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_IN: begin
        mul_a = held_t'(smp_r[cmd.ch]);
        mul_b = MUL_B_W'(in_gain_r);
      end
      OP_POS_X, OP_NEG_X: begin
        mul_a = x_r;
        mul_b = MUL_B_W'(W_SOFT);
      end
      OP_POS_H, OP_NEG_H: begin
        mul_a = held_r[cmd.ch];
        mul_b = MUL_B_W'(W_HARD);
      end
      OP_CLIP_P, OP_CLIP_N: begin
        mul_a = held_r[cmd.ch];
        mul_b = MUL_B_W'(W_SOFT);
      end
      OP_OUT: begin
        mul_a = held_r[cmd.ch];
        mul_b = MUL_B_W'(out_gain_r);
      end
      default: begin
        mul_a = x_r;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * $signed({1'b0, mul_b});

  // clip-level term of the blend
  always_comb begin
    case (cmd.op)
      OP_POS_X, OP_CLIP_P: k = prod_t'(K_RH);
      OP_POS_H:            k = prod_t'(K_RS);
      OP_NEG_X, OP_CLIP_N: k = prod_t'(-K_RH);
      OP_NEG_H:            k = prod_t'(-K_RS);
      default:             k = '0;
    endcase
  end

  assign sum    = p_r + k;
  assign sh_in  = sum >>> IN_SHIFT;
  assign sh_out = sum >>> OUT_SHIFT;
  assign sh_bl  = sum >>> BLEND_SHIFT;

  assign x_in  = (sh_in > prod_t'(FOUR))  ? held_t'(FOUR) :
                 (sh_in < prod_t'(-FOUR)) ? held_t'(-FOUR) : held_t'(sh_in);
  assign blend = held_t'(sh_bl);
  assign y_sat = (sh_out > prod_t'(SMAX)) ? sample_t'(SMAX) :
                 (sh_out < prod_t'(SMIN)) ? sample_t'(SMIN) : sample_t'(sh_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r   <= 1'b0;
      in_gain_r  <= IN_GAIN_RST;
      out_gain_r <= OUT_GAIN_RST;
      held_r[0]  <= '0;
      held_r[1]  <= '0;
      pos_r      <= '0;
      neg_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BYPASS:   bypass_r   <= cfg_data[0];
          CFG_IN_GAIN:  in_gain_r  <= cfg_data[IN_GAIN_W-1:0];
          CFG_OUT_GAIN: out_gain_r <= cfg_data[OUT_GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_POS_X, OP_POS_H: begin
            held_r[cmd.ch] <= blend;
            pos_r[cmd.ch]  <= 1'b0;
          end
          OP_CLIP_P: pos_r[cmd.ch] <= 1'b1;
          OP_NEG_X, OP_NEG_H: begin
            held_r[cmd.ch] <= blend;
            neg_r[cmd.ch]  <= 1'b0;
          end
          OP_CLIP_N: neg_r[cmd.ch] <= 1'b1;
          OP_OUT:    held_r[cmd.ch] <= x_r;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r[0] <= in_left;
      smp_r[1] <= in_right;
      if (bypass_r) begin
        y_r[0] <= in_left;
        y_r[1] <= in_right;
      end
    end
    if (cmd.mul) begin
      p_r <= prod;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_IN:                x_r <= x_in;
        OP_CLIP_P, OP_CLIP_N: x_r <= blend;
        OP_OUT:               y_r[cmd.ch] <= y_sat;
        default: ;
      endcase
    end
    if (cmd.publish) begin
      out_left_r  <= y_r[0];
      out_right_r <= y_r[1];
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  assign stat.bypass     = bypass_r;
  assign stat.pos_flag   = pos_r;
  assign stat.neg_flag   = neg_r;
  assign stat.x_gt_clip  = x_r > held_t'(CLIP_LVL);
  assign stat.x_lt_nclip = x_r < held_t'(-CLIP_LVL);
  assign stat.x_lt_held  = x_r < held_r[cmd.ch];
  assign stat.x_gt_held  = x_r > held_r[cmd.ch];

endmodule

// ===== rtl/lsc_ctrl.sv =====
module lsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lsc_pkg::dp_stat_t stat,
  output lsc_pkg::dp_cmd_t  cmd
);
  import lsc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_WB, S_DONE} state_t;
  typedef enum logic [2:0] {
    STEP_IN, STEP_POS, STEP_CLIP_P, STEP_NEG, STEP_CLIP_N, STEP_OUT
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  op_t    op_r, op_nxt;
  logic   ch_r, ch_nxt;
  logic   out_valid_r, out_valid_nxt;

  op_t  op_sel;
  logic pos_go, clipp_go, neg_go, clipn_go;

  // first op still needed from the current step on; unneeded steps are skipped
  assign pos_go   = (step_r <= STEP_POS)    && stat.pos_flag[ch_r];
  assign clipp_go = (step_r <= STEP_CLIP_P) && stat.x_gt_clip;
  assign neg_go   = (step_r <= STEP_NEG)    && stat.neg_flag[ch_r];
  assign clipn_go = (step_r <= STEP_CLIP_N) && stat.x_lt_nclip;

  always_comb begin
    if (step_r == STEP_IN) begin
      op_sel = OP_IN;
    end else if (pos_go) begin
      op_sel = stat.x_lt_held ? OP_POS_X : OP_POS_H;
    end else if (clipp_go) begin
      op_sel = OP_CLIP_P;
    end else if (neg_go) begin
      op_sel = stat.x_gt_held ? OP_NEG_X : OP_NEG_H;
    end else if (clipn_go) begin
      op_sel = OP_CLIP_N;
    end else begin
      op_sel = OP_OUT;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    cmd         = '0;
    cmd.ch      = ch_r;
    cmd.op      = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          ch_nxt    = 1'b0;
          step_nxt  = STEP_IN;
          state_nxt = stat.bypass ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cmd.op    = op_sel;
        op_nxt    = op_sel;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (op_r == OP_OUT) begin
          if (ch_r) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt    = 1'b1;
            step_nxt  = STEP_IN;
            state_nxt = S_MUL;
          end
        end else begin
          case (op_r)
            OP_IN:              step_nxt = STEP_POS;
            OP_POS_X, OP_POS_H: step_nxt = STEP_CLIP_P;
            OP_CLIP_P:          step_nxt = STEP_NEG;
            OP_NEG_X, OP_NEG_H: step_nxt = STEP_CLIP_N;
            default:            step_nxt = STEP_OUT;
          endcase
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_IN;
      op_r        <= OP_IN;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      op_r        <= op_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
